### src/feedback_delay_network_reverb_assert.svh
// assertion macros used by the checker file
`ifndef FEEDBACK_DELAY_NETWORK_REVERB_ASSERT_SVH
`define FEEDBACK_DELAY_NETWORK_REVERB_ASSERT_SVH

// next-cycle implication that also holds while reset is high
`define FDNR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("fdnr assertion failed");

// next-cycle implication checked outside reset
`define FDNR_ASSERT_NEXT_RUN(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdnr assertion failed");

`endif

### src/fdnr_pkg.sv
package fdnr_pkg;

   localparam int ORDER     = 4;
   localparam int MAX_DELAY = 4096;
   localparam int NUM_TAPS  = 4;

   localparam int SAMPLE_W  = 24;
   localparam int GAIN_W    = 16;
   localparam int TAP_W     = 13;
   localparam int CSR_IDX_W = 4;
   localparam int ADDR_W    = $clog2(MAX_DELAY);
   localparam int LINE_W    = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int FB_W      = SAMPLE_W + LINE_W + 1;
   localparam int STORE_W   = ADDR_W + LINE_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TAP_0   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_1   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_2   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_3   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_IN  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WET_OUT = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_MIX = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY   = 4'd7;

   // 1/sqrt(order) in q1.16, for orders 1 to 4
   function automatic int hscale_of(input int ord);
      case ((ord - 1) & 3)
         0:       return 65536;
         1:       return 46341;
         2:       return 37837;
         default: return 32768;
      endcase
   endfunction

   localparam int HSCALE = hscale_of(ORDER);

   // largest power of two not above the order
   function automatic int pow2_floor(input int ord);
      int p;
      p = 1;
      while (p * 2 <= ord) p = p * 2;
      return p;
   endfunction

   localparam int HAD_P = pow2_floor(ORDER);

   // hadamard entry: zero outside the power-of-two corner
   function automatic logic had_zero(input logic [LINE_W-1:0] r, input logic [LINE_W-1:0] c);
      return (int'(r) >= HAD_P) || (int'(c) >= HAD_P);
   endfunction

   // hadamard entry sign: negative on odd parity of the bitwise and of r and c
   function automatic logic had_neg(input logic [LINE_W-1:0] r, input logic [LINE_W-1:0] c);
      return ^(r & c);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'sh7fffff;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[SAMPLE_W-1:0];
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_WRITE,
      ST_MUL,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic                       valid;
      logic [LINE_W-1:0]          line;
      logic signed [SAMPLE_W-1:0] hist;
      logic signed [FB_W-1:0]     fb;
   } line_req_type;

   typedef struct packed {
      logic                       valid;
      logic [LINE_W-1:0]          line;
      logic signed [SAMPLE_W-1:0] y;
   } line_res_type;

endpackage

### src/fdnr_line_mix.sv
module fdnr_line_mix import fdnr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  line_req_type        req,
   input  logic [GAIN_W-1:0]   dry_in_gain,
   input  logic [GAIN_W-1:0]   decay_gain,
   output line_res_type        res
);

   localparam logic signed [17:0] HS_S = 18'(HSCALE);

   logic                            m_v_ff;
   logic [LINE_W-1:0]               m_n_ff;
   logic signed [SAMPLE_W+GAIN_W:0] m1_ff, m1_in;
   logic signed [FB_W+GAIN_W:0]     m2_ff, m2_in;
   logic signed [63:0]              v;
   line_res_type                    res_ff, res_in;

   // first stage: dry and feedback products
   assign m1_in = req.hist * $signed({1'b0, dry_in_gain});
   assign m2_in = req.fb * $signed({1'b0, decay_gain});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else begin
         m_v_ff <= req.valid;
      end
      m_n_ff <= req.line;
      m1_ff  <= m1_in;
      m2_ff  <= m2_in;
   end

   // second stage: scale, round and saturate
   always_comb begin
      v = (64'(m1_ff) <<< 18) + 64'(m2_ff) * 64'(HS_S) + (64'sd1 <<< 31);
      res_in.valid = m_v_ff;
      res_in.line  = m_n_ff;
      res_in.y     = sat24(v >>> 32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
      res_ff.line <= res_in.line;
      res_ff.y    <= res_in.y;
   end

   assign res = res_ff;

endmodule

### src/feedback_delay_network_reverb.sv
// a result is valid once all tap reads, the writeback of each line and the output mix are done,
//    and later while an earlier result is still stalled at the output
// one item at a time: the input stalls until the result is loaded; pace is set by the single
//    read port of the line store (one tap read per cycle) and the writeback of each line
// reset clears registers and sequencer; the stores are not swept, a fill count
//    makes never-written entries read as zero
module feedback_delay_network_reverb import fdnr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [GAIN_W-1:0]          csr_data
);

   localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(ORDER - 1);
   localparam logic [TAP_W-1:0]  TAP_MAX   = TAP_W'(MAX_DELAY);

   // configuration
   logic [TAP_W-1:0]  tap_ff [NUM_TAPS];
   logic [GAIN_W-1:0] dry_in_ff, wet_out_ff, dry_mix_ff, decay_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TAPS; k++) tap_ff[k] <= TAP_W'(1);
         dry_in_ff  <= '0;
         wet_out_ff <= '0;
         dry_mix_ff <= GAIN_W'(16384);
         decay_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TAP_0:   tap_ff[0]  <= csr_data[TAP_W-1:0];
            REG_TAP_1:   tap_ff[1]  <= csr_data[TAP_W-1:0];
            REG_TAP_2:   tap_ff[2]  <= csr_data[TAP_W-1:0];
            REG_TAP_3:   tap_ff[3]  <= csr_data[TAP_W-1:0];
            REG_DRY_IN:  dry_in_ff  <= csr_data;
            REG_WET_OUT: wet_out_ff <= csr_data;
            REG_DRY_MIX: dry_mix_ff <= csr_data;
            REG_DECAY:   decay_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer state
   seq_state_type state_ff, state_in;
   logic [LINE_W-1:0]          rn_ff, ri_ff, wn_ff;
   logic [ADDR_W-1:0]          pos_ff;
   logic                       full_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       accept, rsp_free, last_read, y_last;
   logic                       issue_rd, do_write, do_load;
   line_res_type               res;

   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid || !rsp_stall;
   assign last_read = (rn_ff == LAST_LINE) && (ri_ff == LAST_LINE);
   assign y_last    = res.valid && (res.line == LAST_LINE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  if (last_read) state_in = ST_DRAIN;
         ST_DRAIN: if (y_last) state_in = ST_WRITE;
         ST_WRITE: if (wn_ff == LAST_LINE) state_in = ST_MUL;
         ST_MUL:   state_in = ST_OUT;
         ST_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      issue_rd  = 1'b0;
      do_write  = 1'b0;
      do_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_READ:  issue_rd  = 1'b1;
         ST_WRITE: do_write  = 1'b1;
         ST_OUT:   do_load   = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rn_ff    <= '0;
         ri_ff    <= '0;
         wn_ff    <= '0;
         pos_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            rn_ff <= '0;
            ri_ff <= '0;
            wn_ff <= '0;
         end
         if (issue_rd) begin
            if (ri_ff == LAST_LINE) begin
               ri_ff <= '0;
               rn_ff <= rn_ff + 1'b1;
            end else begin
               ri_ff <= ri_ff + 1'b1;
            end
         end
         if (do_write) wn_ff <= wn_ff + 1'b1;
         if (do_load) begin
            pos_ff  <= pos_ff + 1'b1;
            full_ff <= full_ff || (pos_ff == {ADDR_W{1'b1}});
         end
      end
      if (accept) x_ff <= req_sample_in;
   end

   // tap clamp and read index of the current line
   logic [TAP_W-1:0]  tap_cur, tap_cl;
   logic [ADDR_W-1:0] idx;
   logic              idx_ok;

   always_comb begin
      tap_cur = tap_ff[rn_ff];
      if (tap_cur == '0) tap_cl = TAP_W'(1);
      else if (tap_cur > TAP_MAX) tap_cl = TAP_MAX;
      else tap_cl = tap_cur;
      idx    = pos_ff - tap_cl[ADDR_W-1:0];
      idx_ok = full_ff || (idx < pos_ff);
   end

   // history and line stores
   logic signed [SAMPLE_W-1:0] hist_mem [MAX_DELAY];
   logic signed [SAMPLE_W-1:0] line_mem [ORDER * MAX_DELAY];
   logic signed [SAMPLE_W-1:0] hist_rd_ff, line_rd_ff;
   logic signed [SAMPLE_W-1:0] y_ff [ORDER];
   logic [STORE_W-1:0]         rd_addr, wr_addr;

   assign rd_addr = {ri_ff, idx};
   assign wr_addr = {wn_ff, pos_ff};

   always_ff @(posedge clock) begin
      if (do_write && (wn_ff == '0)) hist_mem[pos_ff] <= x_ff;
      hist_rd_ff <= hist_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (do_write) line_mem[wr_addr] <= y_ff[wn_ff];
      line_rd_ff <= line_mem[rd_addr];
   end

   // read tags are registered alongside the read data
   logic              rd_v_ff, rd_ok_ff;
   logic [LINE_W-1:0] rd_n_ff, rd_i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= issue_rd;
      end
      rd_n_ff  <= rn_ff;
      rd_i_ff  <= ri_ff;
      rd_ok_ff <= idx_ok;
   end

   // feedback accumulation over the lines
   logic signed [FB_W-1:0]     fb_ff, fb_in, term;
   logic signed [SAMPLE_W-1:0] hist_keep_ff, hist_now, line_now;
   line_req_type               mix_req;

   always_comb begin
      line_now = rd_ok_ff ? line_rd_ff : '0;
      hist_now = rd_ok_ff ? hist_rd_ff : '0;
      if (had_zero(rd_n_ff, rd_i_ff)) term = '0;
      else if (had_neg(rd_n_ff, rd_i_ff)) term = -FB_W'(line_now);
      else term = FB_W'(line_now);
      fb_in = ((rd_i_ff == '0) ? '0 : fb_ff) + term;
      mix_req.valid = rd_v_ff && (rd_i_ff == LAST_LINE);
      mix_req.line  = rd_n_ff;
      mix_req.hist  = (rd_i_ff == '0) ? hist_now : hist_keep_ff;
      mix_req.fb    = fb_in;
   end

   always_ff @(posedge clock) begin
      if (rd_v_ff) fb_ff <= fb_in;
      if (rd_v_ff && (rd_i_ff == '0)) hist_keep_ff <= hist_now;
   end

   fdnr_line_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .req         (mix_req),
      .dry_in_gain (dry_in_ff),
      .decay_gain  (decay_ff),
      .res         (res)
   );

   // line results and wet sum
   logic signed [FB_W-1:0] wsum_ff;

   always_ff @(posedge clock) begin
      if (accept) wsum_ff <= '0;
      else if (res.valid) wsum_ff <= wsum_ff + FB_W'(res.y);
      if (res.valid) y_ff[res.line] <= res.y;
   end

   // output mix
   logic signed [SAMPLE_W+GAIN_W:0] p1_ff;
   logic signed [FB_W+GAIN_W:0]     p2_ff;
   logic signed [63:0]              acc;
   logic                            rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]      rsp_out_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         p1_ff <= x_ff * $signed({1'b0, dry_mix_ff});
         p2_ff <= wsum_ff * $signed({1'b0, wet_out_ff});
      end
   end

   assign acc = 64'(p1_ff) + 64'(p2_ff) + 64'sd8192;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (do_load) rsp_out_ff <= sat24(acc >>> 14);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_out_ff;

endmodule

### src/fdnr_checker.sv
`include "feedback_delay_network_reverb_assert.svh"

module fdnr_checker import fdnr_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic signed [SAMPLE_W-1:0] req_sample_in,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input logic [CSR_IDX_W-1:0]       csr_index,
   input logic [GAIN_W-1:0]          csr_data
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // no result is left over from before reset
   `FDNR_ASSERT_NEXT(a_rsp_clear, reset, !rsp_valid)

   // an accepted item blocks the input while it is worked on
   `FDNR_ASSERT_NEXT_RUN(a_busy, req_take, req_stall)

   // a result cannot appear in the cycle after an item is taken
   `FDNR_ASSERT_NEXT_RUN(a_min_latency, req_take && !rsp_valid, !rsp_valid)

   // a stalled result holds
   `FDNR_ASSERT_NEXT_RUN(a_rsp_hold, rsp_valid && rsp_stall,
                         rsp_valid && $stable(rsp_sample_out))

endmodule

bind feedback_delay_network_reverb fdnr_checker u_fdnr_checker (.*);

### tb/reverb_checker.sv
`timescale 1ns / 100ps

module reverb_checker import fdnr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [GAIN_W-1:0]          csr_data,
   output int                         fail_count,
   output int                         pending_count
);

   // predictor copy of the block's registers and stores
   logic [TAP_W-1:0]           tap_reg [NUM_TAPS];
   logic [GAIN_W-1:0]          dry_in_reg, wet_out_reg, dry_mix_reg, decay_reg;
   logic signed [SAMPLE_W-1:0] hist_mem [MAX_DELAY];
   logic signed [SAMPLE_W-1:0] line_mem [ORDER][MAX_DELAY];
   int                         wr_pos;
   logic signed [SAMPLE_W-1:0] expected_out[$];

   assign pending_count = expected_out.size();

   function automatic longint floor_div(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip24(input longint v);
      if (v > 64'sd8388607) return 24'sh7fffff;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic int had_pattern(input int r, input int c);
      int p;
      p = 1;
      while (p * 2 <= ORDER) p = p * 2;
      if (r >= p || c >= p) return 0;
      return ($countones(r & c) % 2) ? -1 : 1;
   endfunction

   // one sample through the delay network, pushes the mixed output onto the expectation queue
   task automatic reverb_sample(input logic signed [SAMPLE_W-1:0] x);
      logic signed [SAMPLE_W-1:0] y [ORDER];
      longint wet_sum, acc, fb, v;
      int t, idx, s;
      wet_sum = 0;
      for (int n = 0; n < ORDER; n++) begin
         t = tap_reg[n];
         if (t < 1) t = 1;
         if (t > MAX_DELAY) t = MAX_DELAY;
         idx = (wr_pos >= t) ? wr_pos - t : wr_pos + MAX_DELAY - t;
         fb = 0;
         for (int i = 0; i < ORDER; i++) begin
            s = had_pattern(n, i);
            fb += s * longint'(line_mem[i][idx]);
         end
         v = longint'(hist_mem[idx]) * longint'(dry_in_reg) * 262144
           + fb * longint'(decay_reg) * HSCALE;
         y[n] = clip24(floor_div(v + (64'sd1 <<< 31), 32));
         wet_sum += y[n];
      end
      for (int n = 0; n < ORDER; n++) line_mem[n][wr_pos] = y[n];
      hist_mem[wr_pos] = x;
      wr_pos = (wr_pos + 1) % MAX_DELAY;
      acc = longint'(x) * longint'(dry_mix_reg) + wet_sum * longint'(wet_out_reg);
      expected_out.push_back(clip24(floor_div(acc + 8192, 14)));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_TAPS; n++) tap_reg[n] <= TAP_W'(1);
         dry_in_reg  <= '0;
         wet_out_reg <= '0;
         dry_mix_reg <= GAIN_W'(16384);
         decay_reg   <= '0;
         for (int a = 0; a < MAX_DELAY; a++) begin
            hist_mem[a] = '0;
            for (int n = 0; n < ORDER; n++) line_mem[n][a] = '0;
         end
         wr_pos = 0;
         fail_count = 0;
         expected_out.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TAP_0:   tap_reg[0] <= csr_data[TAP_W-1:0];
               REG_TAP_1:   tap_reg[1] <= csr_data[TAP_W-1:0];
               REG_TAP_2:   tap_reg[2] <= csr_data[TAP_W-1:0];
               REG_TAP_3:   tap_reg[3] <= csr_data[TAP_W-1:0];
               REG_DRY_IN:  dry_in_reg  <= csr_data;
               REG_WET_OUT: wet_out_reg <= csr_data;
               REG_DRY_MIX: dry_mix_reg <= csr_data;
               REG_DECAY:   decay_reg   <= csr_data;
               default: ;
            endcase
         end
         // compare result item with oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               $error("unexpected result item sample_out=%0d", rsp_sample_out);
               fail_count++;
            end else begin
               if (rsp_sample_out !== expected_out[0]) begin
                  $error("sample_out expected %0d actual %0d", expected_out[0],
                         rsp_sample_out);
                  fail_count++;
               end
               void'(expected_out.pop_front());
            end
         end
         if (req_valid && !req_stall) reverb_sample(req_sample_in);
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import fdnr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 60;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [GAIN_W-1:0]          csr_data;
   int                         fail_count;
   int                         pending_count;
   int                         cycle_count;
   bit                         quiet_run;

   feedback_delay_network_reverb DUT (.*);

   reverb_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // receiver stall, off during the quiet stretch
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet_run && ($urandom_range(99) < 17);
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // send one sample item with optional idle cycles ahead of it
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
      while (!quiet_run && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_setting(input int t0, input int t1, input int t2, input int t3,
                               input int din, input int wout, input int dmix,
                               input int dec);
      write_reg(REG_TAP_0, GAIN_W'(t0));
      write_reg(REG_TAP_1, GAIN_W'(t1));
      write_reg(REG_TAP_2, GAIN_W'(t2));
      write_reg(REG_TAP_3, GAIN_W'(t3));
      write_reg(REG_DRY_IN, GAIN_W'(din));
      write_reg(REG_WET_OUT, GAIN_W'(wout));
      write_reg(REG_DRY_MIX, GAIN_W'(dmix));
      write_reg(REG_DECAY, GAIN_W'(dec));
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(5))
         0:       return 24'sh7fffff;
         1:       return 24'sh800000;
         2:       return $signed(24'($urandom_range(2000))) - 24'sd1000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      quiet_run     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes
      send_sample(24'sh7fffff);
      send_sample(24'sh800000);
      send_sample(24'sd0);
      send_sample(-24'sd1);
      send_sample(24'sh555555);
      send_sample(24'shaaaaaa);
      drain_results();

      // directed: max gains, taps 0 and beyond range, index past register list
      load_setting(0, 8191, 4096, 2, 65535, 65535, 65535, 65535);
      write_reg(4'd9, 16'hffff);
      write_reg(4'd15, 16'h0000);
      for (int k = 0; k < 12; k++) send_sample(k[0] ? 24'sh7fffff : 24'sh800000);
      drain_results();

      // random phases with several settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_setting(1, 2, 3, 5, 16384, 16384, 16384, 50000);
            1: load_setting(4096, 4096, 4096, 4096, 65535, 0, 0, 65535);
            2: load_setting(7, 11, 13, 17, 8000, 30000, 9000, 60000);
            3: load_setting(0, 0, 0, 0, 0, 65535, 65535, 0);
            default: load_setting($urandom_range(8191), $urandom_range(40),
                                  $urandom_range(8191), $urandom_range(1, 9),
                                  $urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535));
         endcase
         quiet_run = (ph == 2);
         for (int k = 0; k < 105; k++) send_sample(rand_sample());
         quiet_run = 1'b0;
         drain_results();
      end

      if (fail_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
